// File: hw/rtl/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int MAX_DIGITS = 31;

  localparam int RADIX_WIDTH = 6;
  localparam int CHAR_WIDTH = 7;
  localparam int DIGIT_WIDTH = 6;

  localparam int RADIX_RESET = 10;
  localparam int RADIX_MIN = 2;
  localparam int RADIX_MAX = 36;

  localparam int CHAR_DIGIT_BASE = 48;
  localparam int CHAR_LETTER_BASE = 87;
  localparam int LAST_DECIMAL_DIGIT = 9;

  localparam int CHUNK_BITS = 8;
  localparam int NUM_CHUNKS = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_WIDTH = NUM_CHUNKS * CHUNK_BITS;
  localparam int CHUNK_CNT_WIDTH = $clog2(NUM_CHUNKS + 1);

  localparam int COUNT_WIDTH = $clog2(MAX_DIGITS + 1);
  localparam int INDEX_WIDTH = $clog2(MAX_DIGITS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QFILL_WIDTH = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
  } job_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } qlink_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] base;
    if (d <= DIGIT_WIDTH'(LAST_DECIMAL_DIGIT)) begin
      base = CHAR_WIDTH'(CHAR_DIGIT_BASE);
    end else begin
      base = CHAR_WIDTH'(CHAR_LETTER_BASE);
    end
    return base + CHAR_WIDTH'(d);
  endfunction

endpackage

// File: hw/rtl/itra_ifs.sv
interface itra_num_if;
  logic valid;
  logic ready;
  logic [itra_pkg::VALUE_WIDTH-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface itra_char_if;
  logic valid;
  logic ready;
  logic [itra_pkg::CHAR_WIDTH-1:0] digit_char;
  logic last_char;

  modport source(output valid, output digit_char, output last_char, input ready);
  modport sink(input valid, input digit_char, input last_char, output ready);
endinterface

// File: hw/rtl/itra_front.sv
module itra_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [itra_pkg::RADIX_WIDTH-1:0]  cfg_wdata,
  itra_num_if.sink                          num,
  output itra_pkg::qlink_t                  push,
  input  logic                              push_ready,
  output itra_pkg::job_t                    job
);

  logic [itra_pkg::RADIX_WIDTH-1:0] radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itra_pkg::RADIX_WIDTH'(itra_pkg::RADIX_RESET);
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_comb begin
    if (radix < itra_pkg::RADIX_WIDTH'(itra_pkg::RADIX_MIN)) begin
      job.radix = itra_pkg::RADIX_WIDTH'(itra_pkg::RADIX_MIN);
    end else if (radix > itra_pkg::RADIX_WIDTH'(itra_pkg::RADIX_MAX)) begin
      job.radix = itra_pkg::RADIX_WIDTH'(itra_pkg::RADIX_MAX);
    end else begin
      job.radix = radix;
    end
    job.value = num.value;
  end

  assign num.ready  = push_ready;
  assign push.valid = num.valid;
  assign push.ready = push_ready;

endmodule

// File: hw/rtl/itra_queue.sv
module itra_queue (
  input  logic             clk,
  input  logic             rst,
  input  itra_pkg::qlink_t push,
  input  itra_pkg::job_t   push_job,
  output logic             push_ready,
  output logic             pop_valid,
  input  logic             pop,
  output itra_pkg::job_t   pop_job
);

  itra_pkg::job_t entries [itra_pkg::QUEUE_DEPTH];
  logic [itra_pkg::QPTR_WIDTH-1:0]  wr_ptr;
  logic [itra_pkg::QPTR_WIDTH-1:0]  rd_ptr;
  logic [itra_pkg::QFILL_WIDTH-1:0] fill;
  logic do_push;
  logic do_pop;

  assign push_ready = (fill != itra_pkg::QFILL_WIDTH'(itra_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push.valid && push.ready && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == itra_pkg::QPTR_WIDTH'(itra_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == itra_pkg::QPTR_WIDTH'(itra_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/itra_back.sv
module itra_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_pop,
  input  itra_pkg::job_t job,
  itra_char_if.source    chars
);

  itra_pkg::back_state_t state;
  itra_pkg::back_state_t state_next;

  logic [itra_pkg::DIGIT_WIDTH-1:0]     store [itra_pkg::MAX_DIGITS];
  logic [itra_pkg::PAD_WIDTH-1:0]       work;
  logic [itra_pkg::PAD_WIDTH-1:0]       work_next;
  logic [itra_pkg::DIGIT_WIDTH-1:0]     rem;
  logic [itra_pkg::DIGIT_WIDTH-1:0]     rem_next;
  logic [itra_pkg::RADIX_WIDTH-1:0]     radix;
  logic [itra_pkg::CHUNK_CNT_WIDTH-1:0] chunk;
  logic [itra_pkg::COUNT_WIDTH-1:0]     count;
  logic [itra_pkg::INDEX_WIDTH-1:0]     idx;
  logic [itra_pkg::CHUNK_BITS-1:0]      qbits;
  logic [itra_pkg::DIGIT_WIDTH:0]       trial;
  logic                                 out_valid;
  logic [itra_pkg::CHAR_WIDTH-1:0]      out_char;
  logic                                 out_last;
  logic                                 chunk_last;
  logic                                 digits_done;
  logic                                 load_out;

  // Eight restoring steps per cycle; the remainder stays below the radix throughout.
  always_comb begin
    rem_next = rem;
    qbits    = '0;
    trial    = '0;
    for (int i = itra_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
      trial = {rem_next, work[itra_pkg::PAD_WIDTH - itra_pkg::CHUNK_BITS + i]};
      if (trial >= {1'b0, radix}) begin
        trial    = trial - {1'b0, radix};
        qbits[i] = 1'b1;
      end
      rem_next = trial[itra_pkg::DIGIT_WIDTH-1:0];
    end
    work_next = (work << itra_pkg::CHUNK_BITS) | itra_pkg::PAD_WIDTH'(qbits);
  end

  assign chunk_last  = (chunk == itra_pkg::CHUNK_CNT_WIDTH'(itra_pkg::NUM_CHUNKS - 1));
  assign digits_done = (work_next == '0) ||
                       (count == itra_pkg::COUNT_WIDTH'(itra_pkg::MAX_DIGITS - 1));
  assign load_out    = !out_valid || chars.ready;

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    unique case (state)
      itra_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = itra_pkg::ST_DIVIDE;
        end
      end
      itra_pkg::ST_DIVIDE: begin
        if (chunk_last && digits_done) begin
          state_next = itra_pkg::ST_EMIT;
        end
      end
      itra_pkg::ST_EMIT: begin
        if (load_out && idx == '0) begin
          state_next = itra_pkg::ST_IDLE;
        end
      end
      default: state_next = itra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == itra_pkg::ST_DIVIDE && chunk_last) begin
      store[count[itra_pkg::INDEX_WIDTH-1:0]] <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk     <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == itra_pkg::ST_IDLE && job_valid) begin
        chunk <= '0;
        count <= '0;
      end else if (state == itra_pkg::ST_DIVIDE) begin
        if (chunk_last) begin
          chunk <= '0;
          count <= count + 1'b1;
          idx   <= count[itra_pkg::INDEX_WIDTH-1:0];
        end else begin
          chunk <= chunk + 1'b1;
        end
      end
      if (state == itra_pkg::ST_EMIT && load_out) begin
        out_valid <= 1'b1;
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == itra_pkg::ST_IDLE && job_valid) begin
      work  <= itra_pkg::PAD_WIDTH'(job.value);
      radix <= job.radix;
      rem   <= '0;
    end else if (state == itra_pkg::ST_DIVIDE) begin
      work <= work_next;
      rem  <= chunk_last ? '0 : rem_next;
    end
    if (state == itra_pkg::ST_EMIT && load_out) begin
      out_char <= itra_pkg::digit_to_ascii(store[idx]);
      out_last <= (idx == '0);
    end
  end

  assign chars.valid      = out_valid;
  assign chars.digit_char = out_char;
  assign chars.last_char  = out_last;

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    state == itra_pkg::ST_DIVIDE |-> rem < radix)
    else $error("remainder not below radix during division");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= itra_pkg::COUNT_WIDTH'(itra_pkg::MAX_DIGITS))
    else $error("digit count beyond capacity");

  a_emit_index_valid: assert property (@(posedge clk) disable iff (rst)
    state == itra_pkg::ST_EMIT |-> itra_pkg::COUNT_WIDTH'(idx) < count)
    else $error("emit index outside the stored digits");

  a_emit_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == itra_pkg::ST_EMIT && load_out && idx == '0) |=>
      (state == itra_pkg::ST_IDLE && out_valid && out_last))
    else $error("final character not flagged at end of request");

endmodule

// File: hw/rtl/integer_to_radix_ascii_unit.sv
// Channel  Direction  Payload                        Accepted when
// num      in         value[30:0]                    num.valid && num.ready
// chars    out        digit_char[6:0], last_char     chars.valid && chars.ready
// cfg      in         cfg_wdata[5:0] (radix)         cfg_we
//
// The divider produces eight quotient bits per cycle while it works on a digit.
// A request is loaded from the queue, divided digit by digit, and then sent out one
// character at a time, most significant digit first.
// A two-entry queue lets new requests be taken while the back end works.
// Reset sets the radix to ten and empties the queue and the output register.
// A stall on chars holds the current character; the queue fills behind it.
module integer_to_radix_ascii_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [itra_pkg::RADIX_WIDTH-1:0] cfg_wdata,
  itra_num_if.sink                         num,
  itra_char_if.source                      chars
);

  itra_pkg::qlink_t push;
  itra_pkg::job_t   push_job;
  itra_pkg::job_t   pop_job;
  logic             push_ready;
  logic             pop_valid;
  logic             pop;

  itra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .num        (num),
    .push       (push),
    .push_ready (push_ready),
    .job        (push_job)
  );

  itra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  itra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job_pop   (pop),
    .job       (pop_job),
    .chars     (chars)
  );

endmodule

// File: test/integer_to_radix_ascii_unit_test.sv
module integer_to_radix_ascii_unit_test;
  import itra_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 160;

  typedef struct {
    logic [CHAR_WIDTH-1:0] digit_char;
    logic                  last_char;
  } char_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [RADIX_WIDTH-1:0] cfg_wdata;

  itra_num_if num_if ();
  itra_char_if chars_if ();

  integer_to_radix_ascii_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .num       (num_if),
    .chars     (chars_if)
  );

  char_item_t expected_chars[$];
  char_item_t oldest_char;
  logic [RADIX_WIDTH-1:0] radix_setting;
  logic idling_on;
  int long_hold_req;
  int error_count;
  int cycle_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d characters outstanding", $time, expected_chars.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Works out the characters of one number in the current radix, most significant first.
  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] number);
    logic [DIGIT_WIDTH-1:0] digits [MAX_DIGITS];
    logic [VALUE_WIDTH-1:0] rest;
    int unsigned base;
    int n;
    char_item_t item;
    if (radix_setting < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_setting > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_setting;
    end
    rest = number;
    n = 0;
    do begin
      digits[n] = DIGIT_WIDTH'(rest % base);
      rest = VALUE_WIDTH'(rest / base);
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (digits[k] <= LAST_DECIMAL_DIGIT) begin
        item.digit_char = CHAR_WIDTH'(CHAR_DIGIT_BASE + digits[k]);
      end else begin
        item.digit_char = CHAR_WIDTH'(CHAR_LETTER_BASE + digits[k]);
      end
      item.last_char = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return VALUE_WIDTH'($urandom_range(0, 100));
      2, 3: return VALUE_WIDTH'($urandom());
      default: return VALUE_WIDTH'($urandom()) >> $urandom_range(1, 30);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_value(input logic [VALUE_WIDTH-1:0] number);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      num_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    num_if.valid <= 1'b1;
    num_if.value <= number;
    @(posedge clk);
    while (!num_if.ready) @(posedge clk);
    predict_digits(number);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    num_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_WIDTH-1:0] radix);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= radix;
    @(negedge clk);
    cfg_we <= 1'b0;
    radix_setting = radix;
  endtask

  task automatic test_reset_radix();
    send_value(0);
    send_value(9);
    send_value(10);
    send_value(31'h7fffffff);
  endtask

  task automatic test_radix_extremes();
    write_radix(2);
    send_value(0);
    send_value(1);
    send_value(31'h7fffffff);
    send_value(31'h40000000);
    write_radix(36);
    send_value(35);
    send_value(36);
    send_value(31'h7fffffff);
    write_radix(0);
    send_value(5);
    write_radix(1);
    send_value(6);
    write_radix(63);
    send_value(35);
    send_value(1295);
    write_radix(37);
    send_value(71);
    write_radix(16);
    send_value(31'h5eadbeef);
    send_value(10);
  endtask

  task automatic test_random_radixes();
    for (int p = 0; p < 8; p++) begin
      write_radix(RADIX_WIDTH'($urandom_range(0, 63)));
      repeat (23) send_value(random_value());
    end
  endtask

  task automatic test_output_backpressure();
    write_radix(2);
    long_hold_req = 300;
    repeat (10) send_value(VALUE_WIDTH'($urandom()) | 31'h40000000);
    wait_drained();
  endtask

  task automatic test_sender_pause();
    write_radix(RADIX_WIDTH'($urandom_range(2, 36)));
    repeat (15) send_value(random_value());
    wait_drained();
    repeat (15) send_value(random_value());
  endtask

  task automatic test_full_rate();
    idling_on = 1'b0;
    write_radix(RADIX_WIDTH'($urandom_range(2, 36)));
    repeat (40) send_value(random_value());
  endtask

  initial begin : output_ready_driver
    int hold_left;
    hold_left = 0;
    chars_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        chars_if.ready <= 1'b0;
      end else if (long_hold_req > 0) begin
        hold_left = long_hold_req - 1;
        long_hold_req = 0;
        chars_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 16) - 1;
        chars_if.ready <= 1'b0;
      end else begin
        chars_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %0d last %0b", $time,
                 chars_if.digit_char, chars_if.last_char);
        error_count++;
      end else begin
        oldest_char = expected_chars.pop_front();
        if (chars_if.digit_char !== oldest_char.digit_char) begin
          $display("%0t: digit_char mismatch, expected %0d, got %0d", $time,
                   oldest_char.digit_char, chars_if.digit_char);
          error_count++;
        end
        if (chars_if.last_char !== oldest_char.last_char) begin
          $display("%0t: last_char mismatch, expected %0b, got %0b", $time,
                   oldest_char.last_char, chars_if.last_char);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    num_if.valid = 1'b0;
    num_if.value = '0;
    radix_setting = RADIX_WIDTH'(RADIX_RESET);
    idling_on = 1'b1;
    long_hold_req = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_radix();
    test_radix_extremes();
    test_random_radixes();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    num_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: integer_to_radix_ascii_unit.f
hw/rtl/itra_pkg.sv
hw/rtl/itra_ifs.sv
hw/rtl/itra_front.sv
hw/rtl/itra_queue.sv
hw/rtl/itra_back.sv
hw/rtl/integer_to_radix_ascii_unit.sv
test/integer_to_radix_ascii_unit_test.sv
